// ===== rtl/rlk_pkg.sv =====
// Shared constants, types and shape tables of the regularized Laplace kernel unit.
`timescale 1ns / 1ps

package rlk_pkg;

    // Word widths
    localparam int DIST_W     = 32;
    localparam int LEN_W      = 32;
    localparam int KIND_W     = 2;
    localparam int OUT_W      = 48;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KIND = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN  = 1'b1;

    // Kernel kinds; the spare code behaves as the third-order double layer
    localparam logic [KIND_W-1:0] KIND_SL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_D5 = 2'd1;
    localparam logic [KIND_W-1:0] KIND_D3 = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 32'd16777216;

    // Shape table: N_ENT+1 points over 0 <= r/d <= REACH
    localparam int N_ENT  = 256;
    localparam int IDX_W  = 8;
    localparam int WT_W   = 16;
    localparam int REACH  = 5;
    localparam int TAB_W  = 35;
    localparam int D5_W   = LEN_W + 3;
    localparam int DIV1_STEPS = IDX_W + WT_W;

    // Final quotient
    localparam int NUM_W = TAB_W + 64;
    localparam int DEN_W = 3 * LEN_W;
    localparam int QUO_W = OUT_W;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [63:0] TWO_OVER_ROOTPI_Q48 = 64'h120DD750429B7;

    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic             sat;
    } t_res;

    typedef logic [N_ENT:0][TAB_W-1:0] t_tab_row;

    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    // Shift-subtract quotient, used only while the tables are built
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] k);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, k}) begin
                rem  = rem - {1'b0, k};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-f) in Q.62 for f in Q.25, f at most one
    function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        term = 64'd1 << 62;
        pos  = term;
        neg  = '0;
        for (int k = 1; k < 64; k++) begin
            if (term != 0) begin
                term = udiv64(mul_shr(term, f, 25), 64'(k));
                if ((k & 1) != 0) neg = neg + term;
                else              pos = pos + term;
            end
        end
        return (pos >= neg) ? pos - neg : 64'd0;
    endfunction

    function automatic t_tab_row build_tab(input logic [KIND_W-1:0] kind);
        t_tab_row    tab;
        logic [63:0] e_one;
        logic [63:0] u;
        logic [63:0] whole;
        logic [63:0] g;
        logic [63:0] gq;
        logic [63:0] w;
        logic [63:0] t;
        logic [63:0] inner;
        e_one = exp_neg_frac(64'd1 << 25);
        for (int i = 0; i <= N_ENT; i++) begin
            u = udiv64((64'd2 * 64'(REACH) * 64'(REACH) * 64'(i) * 64'(i)) << 24,
                       64'(N_ENT) * 64'(N_ENT));
            whole = u >> 25;
            g = exp_neg_frac(u & ((64'd1 << 25) - 64'd1));
            for (int m = 0; m < 64; m++) begin
                if (64'(m) < whole) g = mul_shr(g, e_one, 62);
            end
            t = udiv64((mul_shr(g, u, 24) >> 6) * 64'd2, 64'd15);
            w = '0;
            for (int m = 1; m < 512; m++) begin
                if (t != 0) begin
                    w = w + t;
                    t = udiv64(mul_shr(t, u, 24), 64'(2 * m + 5));
                end
            end
            gq = g >> 6;
            case (kind)
                KIND_SL: inner = udiv64(gq * 64'd8, 64'd3) + mul_shr(w, u, 25);
                KIND_D5: inner = udiv64(gq * 64'd4, 64'd3) + w;
                default: inner = udiv64(gq * 64'd2, 64'd3) + w;
            endcase
            tab[i] = TAB_W'(mul_shr(inner, TWO_OVER_ROOTPI_Q48, 72));
        end
        return tab;
    endfunction

    localparam t_tab_row TAB_SL = build_tab(KIND_SL);
    localparam t_tab_row TAB_D5 = build_tab(KIND_D5);
    localparam t_tab_row TAB_D3 = build_tab(KIND_D3);

    function automatic logic [TAB_W-1:0] tab_read(input logic [KIND_W-1:0] kind,
                                                  input logic [IDX_W:0] idx);
        case (kind)
            KIND_SL: return TAB_SL[idx];
            KIND_D5: return TAB_D5[idx];
            default: return TAB_D3[idx];
        endcase
    endfunction

endpackage

// ===== rtl/rlk_dist_if.sv =====
// Stream interface carrying one distance word per handshake.
`timescale 1ns / 1ps

interface rlk_dist_if;
    logic                      valid;
    logic                      ready;
    logic [rlk_pkg::DIST_W-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

// ===== rtl/rlk_kern_if.sv =====
// Stream interface carrying one kernel result word per handshake.
`timescale 1ns / 1ps

interface rlk_kern_if;
    logic                     valid;
    logic                     ready;
    logic [rlk_pkg::OUT_W-1:0] kernel_value;
    logic                     saturated;

    modport source (output valid, output kernel_value, output saturated, input ready);
    modport sink   (input valid, input kernel_value, input saturated, output ready);
endinterface

// ===== rtl/rlk_quot_pipe.sv =====
// Pipelined restoring divider: one quotient bit per stage, with saturation check.
`timescale 1ns / 1ps

module rlk_quot_pipe (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_vld,
    input  logic [rlk_pkg::NUM_W-1:0] i_num,
    input  logic [rlk_pkg::DEN_W-1:0] i_den,
    output logic                      o_vld,
    output rlk_pkg::t_res             o_res
);
    import rlk_pkg::*;

    logic             r_vld [0:QUO_W];
    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_lo  [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic             r_sat [0:QUO_W];

    logic [DEN_W:0]   cand  [0:QUO_W-1];
    logic             take  [0:QUO_W-1];
    logic [DEN_W-1:0] n_rem [0:QUO_W-1];

    always_comb begin
        for (int j = 0; j < QUO_W; j++) begin
            cand[j]  = {r_rem[j], r_lo[j][QUO_W-1]};
            take[j]  = cand[j] >= {1'b0, r_den[j]};
            n_rem[j] = take[j] ? DEN_W'(cand[j] - {1'b0, r_den[j]}) : cand[j][DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QUO_W; j++) r_vld[j] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int j = 0; j < QUO_W; j++) r_vld[j+1] <= r_vld[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DEN_W'(i_num[NUM_W-1:QUO_W]);
            r_lo[0]  <= i_num[QUO_W-1:0];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            // quotient of 2^48 or more: clip
            r_sat[0] <= DEN_W'(i_num[NUM_W-1:QUO_W]) >= i_den;
            for (int j = 0; j < QUO_W; j++) begin
                r_rem[j+1] <= n_rem[j];
                r_lo[j+1]  <= {r_lo[j][QUO_W-2:0], 1'b0};
                r_den[j+1] <= r_den[j];
                r_q[j+1]   <= {r_q[j][QUO_W-2:0], take[j]};
                r_sat[j+1] <= r_sat[j];
            end
        end
    end

    assign o_vld     = r_vld[QUO_W];
    assign o_res.quo = r_sat[QUO_W] ? OUT_MAX : r_q[QUO_W];
    assign o_res.sat = r_sat[QUO_W];

endmodule

// ===== rtl/regularized_laplace_kernel_unit.sv =====
// Top level of the regularized Laplace kernel unit.
`timescale 1ns / 1ps

// Takes one distance word r (unsigned Q8.24) per cycle and returns one kernel word
// (unsigned Q24.24, truncated, clipped to all ones with the saturated flag set).
// Registers: index 0 selects the kernel (single layer fifth order, double layer fifth
// order, double layer third order; the spare code acts as the third-order double layer),
// index 1 holds the regularization length d in Q8.24 (zero acts as the smallest length).
// Write them only while no word is in flight. Throughput is one word per clock. The
// pipeline is built around two bit-per-stage dividers: 24 stages to locate r/d in the
// shape table and 48 stages for the final quotient f/d, f/d^3, 1/r or 1/r^3. An output
// register with a skid stage behind it lets the unit keep taking distances while a
// result waits; the input stalls only once the skid stage is full.
module regularized_laplace_kernel_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlk_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rlk_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rlk_dist_if.sink                       i_dist,
    rlk_kern_if.source                     o_kern
);
    import rlk_pkg::*;

    // ---------------- configuration ----------------
    logic [KIND_W-1:0] r_kind;
    logic [LEN_W-1:0]  r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_SL;
            r_len  <= LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KIND: r_kind <= i_cfg_data[KIND_W-1:0];
                REG_LEN:  r_len  <= i_cfg_data[LEN_W-1:0];
                default:  ;
            endcase
        end
    end

    logic [LEN_W-1:0] d_eff;
    logic [D5_W-1:0]  d5;
    logic             pw1;

    // a zero length behaves as one LSB
    assign d_eff = (r_len == '0) ? LEN_W'(1) : r_len;
    assign d5    = ({3'b000, d_eff} << 2) + {3'b000, d_eff};
    assign pw1   = (r_kind == KIND_SL);

    // ---------------- flow control ----------------
    // The whole pipe advances together; it halts only while the skid stage holds a word.
    logic r_sk_vld;
    logic en;
    logic acc;

    assign en           = !r_sk_vld;
    assign i_dist.ready = en;
    assign acc          = i_dist.valid && en;

    // ---------------- table locate: p = r*2^24 / 5d ----------------
    // r >= 5d means beyond the table reach; otherwise p < 2^24, one bit per stage.
    logic              r_p_vld [0:DIV1_STEPS];
    logic              r_p_bey [0:DIV1_STEPS];
    logic [DIST_W-1:0] r_p_r   [0:DIV1_STEPS];
    logic [D5_W-1:0]   r_p_rem [0:DIV1_STEPS];
    logic [DIV1_STEPS-1:0] r_p_q [0:DIV1_STEPS];

    logic [D5_W:0]     p_cand  [0:DIV1_STEPS-1];
    logic              p_take  [0:DIV1_STEPS-1];
    logic [D5_W-1:0]   n_p_rem [0:DIV1_STEPS-1];

    always_comb begin
        for (int j = 0; j < DIV1_STEPS; j++) begin
            p_cand[j]  = {r_p_rem[j], 1'b0};
            p_take[j]  = p_cand[j] >= {1'b0, d5};
            n_p_rem[j] = p_take[j] ? D5_W'(p_cand[j] - {1'b0, d5}) : p_cand[j][D5_W-1:0];
        end
    end

    // ---------------- lookup, interpolation and cube ----------------
    logic             r_l_vld, r_x_vld, r_m_vld, r_f_vld;

    logic             r_l_bey;
    logic [DIST_W-1:0] r_l_r;
    logic [TAB_W-1:0] r_l_t0, r_l_t1;
    logic [WT_W-1:0]  r_l_wt;

    logic             r_x_bey, r_x_dsgn;
    logic [TAB_W-1:0] r_x_t0, r_x_diff;
    logic [WT_W-1:0]  r_x_wt;
    logic [LEN_W-1:0] r_x_den;
    logic [2*LEN_W-1:0] r_x_den2;

    logic             r_m_bey, r_m_dsgn;
    logic [TAB_W-1:0] r_m_t0;
    logic [TAB_W+WT_W-1:0] r_m_prod;
    logic [LEN_W-1:0] r_m_den;
    logic [2*LEN_W-1:0] r_m_lo, r_m_hi;

    logic             r_f_bey;
    logic [TAB_W-1:0] r_f_f;
    logic [LEN_W-1:0] r_f_den;
    logic [DEN_W-1:0] r_f_den3;

    logic [IDX_W-1:0] l_idx;
    logic [LEN_W-1:0] x_den;
    logic [TAB_W-1:0] f_step;

    assign l_idx  = r_p_q[DIV1_STEPS][DIV1_STEPS-1:WT_W];
    // beyond the reach the shape term is one and the quotient runs on r instead of d
    assign x_den  = r_l_bey ? r_l_r : d_eff;
    assign f_step = r_m_prod[TAB_W+WT_W-1:WT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= DIV1_STEPS; j++) r_p_vld[j] <= 1'b0;
            r_l_vld <= 1'b0;
            r_x_vld <= 1'b0;
            r_m_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_p_vld[0] <= acc;
            for (int j = 0; j < DIV1_STEPS; j++) r_p_vld[j+1] <= r_p_vld[j];
            r_l_vld <= r_p_vld[DIV1_STEPS];
            r_x_vld <= r_l_vld;
            r_m_vld <= r_x_vld;
            r_f_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_bey[0] <= {3'b000, i_dist.distance} >= d5;
            r_p_r[0]   <= i_dist.distance;
            r_p_rem[0] <= {3'b000, i_dist.distance};
            r_p_q[0]   <= '0;
            for (int j = 0; j < DIV1_STEPS; j++) begin
                r_p_bey[j+1] <= r_p_bey[j];
                r_p_r[j+1]   <= r_p_r[j];
                r_p_rem[j+1] <= n_p_rem[j];
                r_p_q[j+1]   <= {r_p_q[j][DIV1_STEPS-2:0], p_take[j]};
            end

            // read both neighbouring table points
            r_l_bey <= r_p_bey[DIV1_STEPS];
            r_l_r   <= r_p_r[DIV1_STEPS];
            r_l_t0  <= tab_read(r_kind, {1'b0, l_idx});
            r_l_t1  <= tab_read(r_kind, {1'b0, l_idx} + (IDX_W+1)'(1));
            r_l_wt  <= r_p_q[DIV1_STEPS][WT_W-1:0];

            // slope magnitude and direction; square the divisor base
            r_x_bey  <= r_l_bey;
            r_x_t0   <= r_l_t0;
            r_x_dsgn <= r_l_t1 < r_l_t0;
            r_x_diff <= (r_l_t1 < r_l_t0) ? r_l_t0 - r_l_t1 : r_l_t1 - r_l_t0;
            r_x_wt   <= r_l_wt;
            r_x_den  <= x_den;
            r_x_den2 <= {32'd0, x_den} * {32'd0, x_den};

            // weight the slope; cube as two 32x32 partial products
            r_m_bey  <= r_x_bey;
            r_m_dsgn <= r_x_dsgn;
            r_m_t0   <= r_x_t0;
            r_m_prod <= (TAB_W+WT_W)'(r_x_diff) * (TAB_W+WT_W)'(r_x_wt);
            r_m_den  <= r_x_den;
            r_m_lo   <= {32'd0, r_x_den2[LEN_W-1:0]} * {32'd0, r_x_den};
            r_m_hi   <= {32'd0, r_x_den2[2*LEN_W-1:LEN_W]} * {32'd0, r_x_den};

            // interpolated shape value and full cube
            r_f_bey  <= r_m_bey;
            r_f_f    <= r_m_dsgn ? r_m_t0 - f_step : r_m_t0 + f_step;
            r_f_den  <= r_m_den;
            r_f_den3 <= {r_m_hi, 32'd0} + {32'd0, r_m_lo};
        end
    end

    // ---------------- final quotient ----------------
    logic [NUM_W-1:0] q_num;
    logic [DEN_W-1:0] q_den;
    logic             q_vld;
    t_res             q_res;

    always_comb begin
        if (r_f_bey) q_num = pw1 ? NUM_W'(1) << 48 : NUM_W'(1) << 96;
        else         q_num = pw1 ? NUM_W'(r_f_f) << 16 : NUM_W'(r_f_f) << 64;
        q_den = pw1 ? DEN_W'(r_f_den) : r_f_den3;
    end

    rlk_quot_pipe u_quot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_f_vld),
        .i_num   (q_num),
        .i_den   (q_den),
        .o_vld   (q_vld),
        .o_res   (q_res)
    );

    // ---------------- output register and skid stage ----------------
    logic r_o_vld;
    t_res r_o_res;
    t_res r_sk_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld  <= 1'b0;
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            // drain the skid word once the output word is taken
            if (o_kern.ready) r_sk_vld <= 1'b0;
        end else if (q_vld) begin
            if (r_o_vld && !o_kern.ready) r_sk_vld <= 1'b1;
            else                          r_o_vld  <= 1'b1;
        end else if (o_kern.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_vld) begin
            if (o_kern.ready) r_o_res <= r_sk_res;
        end else if (q_vld) begin
            if (r_o_vld && !o_kern.ready) r_sk_res <= q_res;
            else                          r_o_res  <= q_res;
        end
    end

    assign o_kern.valid        = r_o_vld;
    assign o_kern.kernel_value = r_o_res.quo;
    assign o_kern.saturated    = r_o_res.sat;

endmodule

// ===== rtl/rlk_checker.sv =====
// Port-level checks of the kernel unit, bound to its top level.
`timescale 1ns / 1ps

module rlk_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [rlk_pkg::OUT_W-1:0] i_out_value,
    input logic                      i_out_sat
);
    import rlk_pkg::*;

    logic [7:0] r_pend;

    // words taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 8'(i_in_valid && i_in_ready) - 8'(i_out_valid && i_out_ready);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |-> r_pend != 8'd0)
        else $error("result word without a distance word");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result waiting");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_sat |-> i_out_value == OUT_MAX)
        else $error("saturated word not clipped");

endmodule

bind regularized_laplace_kernel_unit rlk_checker u_rlk_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_dist.valid),
    .i_in_ready  (i_dist.ready),
    .i_out_valid (o_kern.valid),
    .i_out_ready (o_kern.ready),
    .i_out_value (o_kern.kernel_value),
    .i_out_sat   (o_kern.saturated)
);
